// ===== design/msrm_pkg.sv =====
package msrm_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] MAX_S32 = 32'sh7FFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic fetch_done;
        logic load_out;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic deep_pop;
    } t_stat;

endpackage

// ===== design/msrm_if.sv =====
interface msrm_in_if
    import msrm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface msrm_out_if
    import msrm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [1:0]               status;

    modport source (output valid, output popped_value, output top_value, output min_value,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input popped_value, input top_value, input min_value,
                    input is_empty, input status, output ready);
endinterface

// ===== design/min_stack_running_min_unit.sv =====
// Signed 32-bit stack of STACK_DEPTH entries that keeps, beside each entry, the minimum of
// that entry and every entry below it, so each result reports the top and the overall
// minimum at once. Each input transfer carries a push, a pop or a peek (the unused code acts
// as a peek) and yields exactly one result transfer with the popped value, the new top, the
// new minimum, an empty flag and a status code (pop on empty and push on full are refused and
// leave the stack unchanged). A push, a peek, a refused operation and a pop that empties the
// stack load the output register when taken; a pop that leaves entries behind passes first
// through a fetch state, because the entry below the top is fetched from a synchronous
// single-port memory with registered read data. The top entry is held in registers, and the
// memory needs no clearing after reset since only entries below the fill count are ever
// read. A finished result waits in an output register, and the next input transfer is taken
// no earlier than the cycle in which that result is taken.
module min_stack_running_min_unit
    import msrm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    msrm_in_if.sink       i_in,
    msrm_out_if.source    o_out
);

    t_ctl  ctl;
    t_stat stat;

    // The controller sequences transfers; the datapath holds the stack and the result.
    msrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    msrm_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_cmd          (i_in.cmd),
        .i_push_value   (i_in.push_value),
        .o_popped_value (o_out.popped_value),
        .o_top_value    (o_out.top_value),
        .o_min_value    (o_out.min_value),
        .o_is_empty     (o_out.is_empty),
        .o_status       (o_out.status)
    );

    // A pop that needs the memory delivers its result once the fetch state has loaded the output register.
    a_deep_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.accept && stat.deep_pop |=> ##1 o_out.valid)
        else $error("deep pop result not delivered on time");

    // An empty stack reports a zero top and minimum.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_empty |-> (o_out.top_value == '0) && (o_out.min_value == '0))
        else $error("empty result carries non-zero top or minimum");

    // The running minimum never exceeds the top entry.
    a_min_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_empty |-> (o_out.min_value <= o_out.top_value))
        else $error("minimum above top entry");

    // A refused push can only happen on a non-empty stack.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_FULL) |-> !o_out.is_empty)
        else $error("push refused on an empty stack");

endmodule

// ===== design/msrm_ctrl.sv =====
module msrm_ctrl
    import msrm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_ctl.accept     = 1'b0;
        o_ctl.fetch_done = 1'b0;
        o_ctl.load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = slot_free;
                o_ctl.accept = i_in_valid && slot_free;
                if (o_ctl.accept) begin
                    if (i_stat.deep_pop) begin
                        n_state = S_FETCH;
                    end else begin
                        o_ctl.load_out = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                // The output slot was freed when this pop was taken.
                o_ctl.fetch_done = 1'b1;
                o_ctl.load_out   = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_ctl.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/msrm_dpath.sv =====
module msrm_dpath
    import msrm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    output t_stat                    o_stat,
    input  logic [1:0]               i_cmd,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic signed [DATA_W-1:0] o_top_value,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic                     o_is_empty,
    output logic [1:0]               o_status
);

    // Entries below the top; the top entry itself lives in registers.
    logic [2*DATA_W-1:0] mem [STACK_DEPTH];
    logic [2*DATA_W-1:0] r_rdata;

    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_top_val, n_top_val;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;
    logic signed [DATA_W-1:0] r_popped;

    logic signed [DATA_W-1:0] r_o_popped, n_o_popped;
    logic signed [DATA_W-1:0] r_o_top, n_o_top;
    logic signed [DATA_W-1:0] r_o_min, n_o_min;
    logic                     r_o_empty, n_o_empty;
    logic [1:0]               r_o_status, n_o_status;

    logic                     is_zero, is_one, is_full;
    logic signed [DATA_W-1:0] run_min, new_min;
    logic                     do_write, do_read;
    logic [CNT_W-1:0]         wr_cnt, rd_cnt;

    assign is_zero = (r_count == '0);
    assign is_one  = (r_count == CNT_W'(1));
    assign is_full = (r_count == CNT_W'(STACK_DEPTH));
    assign run_min = is_zero ? MAX_S32 : r_top_min;
    assign new_min = (i_push_value < run_min) ? i_push_value : run_min;
    assign wr_cnt  = r_count - CNT_W'(1);
    assign rd_cnt  = r_count - CNT_W'(2);

    assign o_stat.deep_pop = (i_cmd == CMD_POP) && !is_zero && !is_one;
    assign do_write = i_ctl.accept && (i_cmd == CMD_PUSH) && !is_full && !is_zero;
    assign do_read  = i_ctl.accept && o_stat.deep_pop;

    always_comb begin
        n_count    = r_count;
        n_top_val  = r_top_val;
        n_top_min  = r_top_min;
        n_o_popped = '0;
        n_o_top    = is_zero ? '0 : r_top_val;
        n_o_min    = is_zero ? '0 : r_top_min;
        n_o_empty  = is_zero;
        n_o_status = ST_OK;
        if (i_ctl.fetch_done) begin
            n_top_val  = $signed(r_rdata[DATA_W-1:0]);
            n_top_min  = $signed(r_rdata[2*DATA_W-1:DATA_W]);
            n_o_popped = r_popped;
            n_o_top    = $signed(r_rdata[DATA_W-1:0]);
            n_o_min    = $signed(r_rdata[2*DATA_W-1:DATA_W]);
            n_o_empty  = 1'b0;
        end else if (i_ctl.accept) begin
            case (i_cmd)
                CMD_PUSH: begin
                    if (is_full) begin
                        n_o_status = ST_FULL;
                    end else begin
                        n_count   = r_count + CNT_W'(1);
                        n_top_val = i_push_value;
                        n_top_min = new_min;
                        n_o_top   = i_push_value;
                        n_o_min   = new_min;
                        n_o_empty = 1'b0;
                    end
                end
                CMD_POP: begin
                    if (is_zero) begin
                        n_o_status = ST_EMPTY;
                    end else begin
                        n_count    = wr_cnt;
                        n_o_popped = r_top_val;
                        if (is_one) begin
                            n_o_top   = '0;
                            n_o_min   = '0;
                            n_o_empty = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[wr_cnt[IDX_W-1:0]] <= {r_top_min, r_top_val};
        end
        if (do_read) begin
            r_rdata <= mem[rd_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_val <= n_top_val;
        r_top_min <= n_top_min;
        if (do_read) begin
            r_popped <= r_top_val;
        end
        if (i_ctl.load_out) begin
            r_o_popped <= n_o_popped;
            r_o_top    <= n_o_top;
            r_o_min    <= n_o_min;
            r_o_empty  <= n_o_empty;
            r_o_status <= n_o_status;
        end
    end

    assign o_popped_value = r_o_popped;
    assign o_top_value    = r_o_top;
    assign o_min_value    = r_o_min;
    assign o_is_empty     = r_o_empty;
    assign o_status       = r_o_status;

endmodule

// ===== test/tb.sv =====
`default_nettype none

// Testbench for the running-minimum stack.
//
// A driver pulls operations from a queue that the initial block fills before reset is
// released, and offers them to the block one transfer at a time. At every accepted input
// transfer the driver runs the operation through the local stack predictor and queues the
// expected result. The monitor takes result transfers and compares them, field by field,
// against the oldest expected result. Both sides idle in random bursts, except over the
// final stretch of the run, where the stream runs at full rate. A watchdog ends the run if
// no transfer happens on either side for too long.
module tb;
    import msrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One operation as offered on the input channel.
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } t_stack_op;

    // One result as seen on the output channel.
    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic signed [DATA_W-1:0] top;
        logic signed [DATA_W-1:0] lowest;
        logic                     empty;
        logic [1:0]               status;
    } t_stack_result;

    localparam int RANDOM_ITEMS  = 310;  // random operations between the directed and tail parts
    localparam int TAIL_ITEMS    = 60;   // closing operations, sent without any idling
    localparam int DRAIN_CYCLES  = 8;    // quiet cycles after the last result
    localparam int STALL_LIMIT   = 2000; // cycles without any transfer before giving up
    localparam int REPORT_LIMIT  = 10;   // mismatches printed in full

    // The spare command code, which the block treats as a peek.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] MIN_S32 = 32'sh8000_0000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    msrm_in_if  in_if();
    msrm_out_if out_if();

    min_stack_running_min_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------------------
    // Stack predictor. Each slot holds a value and the minimum of that value and everything
    // beneath it, so the overall minimum is always found in the top slot.
    // ------------------------------------------------------------------------------------
    logic signed [DATA_W-1:0] slot_value [STACK_DEPTH];
    logic signed [DATA_W-1:0] slot_min   [STACK_DEPTH];
    int                       held_count = 0;
    logic signed [DATA_W-1:0] held_min   = MAX_S32;

    function automatic t_stack_result stack_apply(input logic [1:0] cmd,
                                                  input logic signed [DATA_W-1:0] value);
        t_stack_result res;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (held_count >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (value < held_min)
                        held_min = value;
                    slot_value[held_count] = value;
                    slot_min[held_count]   = held_min;
                    held_count++;
                end
            end
            CMD_POP: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    held_count--;
                    res.popped = slot_value[held_count];
                    held_min   = (held_count > 0) ? slot_min[held_count - 1] : MAX_S32;
                end
            end
            // A peek, and the unused command code, leave the stack as it is.
            default: ;
        endcase
        if (held_count > 0) begin
            res.top    = slot_value[held_count - 1];
            res.lowest = slot_min[held_count - 1];
        end
        res.empty = (held_count == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Stimulus store and a shadow of the fill level as the operations are queued, so that
    // sequences can be shaped around an empty stack.
    // ------------------------------------------------------------------------------------
    t_stack_op     pending_ops[$];
    t_stack_result expected_results[$];
    int            planned_depth  = 0;
    int            total_items    = 0;
    int            accepted_count = 0;
    int            error_count    = 0;

    task automatic queue_op(input logic [1:0] cmd, input logic signed [DATA_W-1:0] value);
        t_stack_op op;
        op.cmd   = cmd;
        op.value = value;
        pending_ops.push_back(op);
        if (cmd == CMD_PUSH && planned_depth < STACK_DEPTH)
            planned_depth++;
        else if (cmd == CMD_POP && planned_depth > 0)
            planned_depth--;
    endtask

    // Values lean towards the extremes and a narrow band around zero, where ties and new
    // minima are frequent; the rest are spread over the whole 32-bit range.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return MIN_S32;
            1:       return MAX_S32;
            2:       return ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
            3, 4, 5: return $signed($urandom_range(0, 200)) - 32'sd100;
            default: return $signed($urandom());
        endcase
    endfunction

    // Weighted mix of every command, the unused code included.
    function automatic logic [1:0] pick_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 42)
            return CMD_PUSH;
        else if (roll < 78)
            return CMD_POP;
        else if (roll < 92)
            return CMD_PEEK;
        else
            return CMD_UNUSED;
    endfunction

    // ------------------------------------------------------------------------------------
    // Driver. At each edge it first records an accepted transfer with the predictor, then
    // decides what the channel offers next. The valid line gets at most one assignment per edge.
    // ------------------------------------------------------------------------------------
    int        gap_left = 0;
    int        gap_pct  = 0;
    t_stack_op next_op;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid      <= 1'b0;
            in_if.cmd        <= CMD_PEEK;
            in_if.push_value <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_results.push_back(stack_apply(in_if.cmd, in_if.push_value));
                accepted_count++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0 || pending_ops.size() == 0) begin
                    in_if.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end else begin
                    next_op = pending_ops.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.cmd        <= next_op.cmd;
                    in_if.push_value <= next_op.value;
                    // Idling comes in bursts after a transfer; the closing stretch has none.
                    if (pending_ops.size() < TAIL_ITEMS) begin
                        gap_left = 0;
                    end else begin
                        if ($urandom_range(0, 39) == 0)
                            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                        if ($urandom_range(0, 99) < gap_pct)
                            gap_left = $urandom_range(1, 19);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Monitor. Each accepted result transfer is checked against the oldest expectation.
    // Back-pressure comes in random bursts, with quiet spells in between.
    // ------------------------------------------------------------------------------------
    int            stall_left = 0;
    int            stall_pct  = 0;
    t_stack_result got_result;
    t_stack_result want_result;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got_result.popped = out_if.popped_value;
                got_result.top    = out_if.top_value;
                got_result.lowest = out_if.min_value;
                got_result.empty  = out_if.is_empty;
                got_result.status = out_if.status;
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected: popped %0d top %0d min %0d empty %0b st %0d",
                                 got_result.popped, got_result.top, got_result.lowest,
                                 got_result.empty, got_result.status);
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.popped !== want_result.popped
                            || got_result.top !== want_result.top
                            || got_result.lowest !== want_result.lowest
                            || got_result.empty !== want_result.empty
                            || got_result.status !== want_result.status) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("expected: popped %0d top %0d min %0d empty %0b st %0d",
                                     want_result.popped, want_result.top, want_result.lowest,
                                     want_result.empty, want_result.status);
                            $display("actual:   popped %0d top %0d min %0d empty %0b st %0d",
                                     got_result.popped, got_result.top, got_result.lowest,
                                     got_result.empty, got_result.status);
                        end
                    end
                end
            end
            if (pending_ops.size() < TAIL_ITEMS) begin
                out_if.ready <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Watchdog. The longest legal pause is a sender gap plus a receiver stall plus the
    // block's own memory fetch for a deep pop, well under the limit.
    // ------------------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus plan, reset and end of run.
    // ------------------------------------------------------------------------------------
    initial begin
        int run_len;
        int start_size;

        // Directed part: every command on an empty stack, the value extremes, a tie with
        // the reset minimum, the unused code, a pop that empties the stack and pops that
        // leave entries behind.
        queue_op(CMD_POP,    32'sd7);
        queue_op(CMD_PEEK,   32'sd0);
        queue_op(CMD_UNUSED, -32'sd1);
        queue_op(CMD_PUSH,   MAX_S32);
        queue_op(CMD_PUSH,   32'sd0);
        queue_op(CMD_PUSH,   MIN_S32);
        queue_op(CMD_PUSH,   -32'sd1);
        queue_op(CMD_PEEK,   MIN_S32);
        queue_op(CMD_UNUSED, MAX_S32);
        queue_op(CMD_PUSH,   MAX_S32);
        queue_op(CMD_POP,    32'sd0);
        queue_op(CMD_POP,    32'sd0);
        queue_op(CMD_POP,    32'sd0);
        queue_op(CMD_POP,    32'sd0);
        queue_op(CMD_POP,    32'sd0);
        queue_op(CMD_POP,    32'sd0);
        queue_op(CMD_PUSH,   32'sd5);
        queue_op(CMD_PUSH,   32'sd5);
        queue_op(CMD_PUSH,   32'sd3);
        queue_op(CMD_POP,    32'sh5555_5555);
        queue_op(CMD_POP,    32'shAAAA_AAAA);
        queue_op(CMD_POP,    32'sd0);
        queue_op(CMD_POP,    32'sd0);

        // Random part: mostly runs of pushes followed by runs of pops, so the stack climbs
        // and drains with minima restored on the way down, plus stretches of mixed noise.
        start_size = pending_ops.size();
        while (pending_ops.size() - start_size < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    run_len = $urandom_range(1, 24);
                    repeat (run_len) queue_op(CMD_PUSH, pick_value());
                    if ($urandom_range(0, 1) == 0)
                        queue_op(CMD_PEEK, pick_value());
                    // Occasionally one pop too many, which must be refused.
                    run_len = $urandom_range(0, planned_depth + 1);
                    repeat (run_len) queue_op(CMD_POP, pick_value());
                end
                2: begin
                    repeat (16) queue_op(pick_cmd(), pick_value());
                end
                default: begin
                    repeat (8) queue_op(2'($urandom_range(0, 3)), $signed($urandom()));
                end
            endcase
        end

        // Closing stretch at full rate on both sides.
        repeat (TAIL_ITEMS) queue_op(pick_cmd(), pick_value());
        total_items = pending_ops.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
